FILE: rtl/adc_two_wire_serial_controller_core_macros.svh
// Assertion macros used by the converter link controller RTL.
`ifndef ADC_TWO_WIRE_SERIAL_CONTROLLER_CORE_MACROS_SVH
`define ADC_TWO_WIRE_SERIAL_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ADCTW_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adctw assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ADCTW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adctw assertion failed");

`endif

FILE: rtl/adctw_pkg.sv
// Types and constants for the two-wire converter link controller.
package adctw_pkg;

    localparam int FUNC_W    = 3;
    localparam int DATA_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int SAMPLE_W  = 24;
    localparam int SUM_W     = 64;
    localparam int COUNT_W   = 32;
    localparam int HALF_W    = 16;
    localparam int TIMEOUT_W = 32;
    localparam int TIMER_W   = 32;
    localparam int PULSE_W   = 6;
    localparam int CMD_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_REGRD = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT  = 2'd2;

    localparam logic [CMD_W-1:0] CMD_WR = 7'h65;
    localparam logic [CMD_W-1:0] CMD_RD = 7'h56;

    // pulse slots of a register access
    localparam logic [PULSE_W-1:0] CMD_FIRST  = 6'd29;
    localparam logic [PULSE_W-1:0] CMD_LAST   = 6'd35;
    localparam logic [PULSE_W-1:0] DATA_FIRST = 6'd37;
    localparam logic [PULSE_W-1:0] DATA_LAST  = 6'd44;
    localparam logic [PULSE_W-1:0] REG_END    = 6'd45;

    localparam int TRAIL_PULSES = 3;
    localparam int EXTRA_LIMIT  = 8;

    localparam logic [HALF_W-1:0]    HALF_RESET    = 16'd50;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd50000000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_READ,
        PH_WAIT,
        PH_REG
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_WRITE,
        KIND_READ
    } kind_t;

    typedef struct packed {
        logic                sck;
        logic                din;
        logic                busy;
        logic                done;
        logic [STATUS_W-1:0] status;
    } tick_t;

    typedef struct packed {
        logic             add;
        logic             clear;
        logic [SUM_W-1:0] value;
    } stat_evt_t;

endpackage

FILE: rtl/adctw_stats.sv
// Sample statistics: wrapping sum and counts.
module adctw_stats (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  adctw_pkg::stat_evt_t      evt,
    output logic [adctw_pkg::SUM_W-1:0]   sample_sum,
    output logic [adctw_pkg::COUNT_W-1:0] sample_count,
    output logic [adctw_pkg::COUNT_W-1:0] sample_total
);
    import adctw_pkg::*;

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] total_reg, total_next;

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        total_next = total_reg;
        if (evt.clear)
        begin
            sum_next   = '0;
            count_next = '0;
        end
        else if (evt.add)
        begin
            sum_next   = sum_reg + evt.value;
            count_next = count_reg + COUNT_W'(1);
            total_next = total_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            total_reg <= '0;
        end
        else if (step)
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    assign sample_sum   = sum_reg;
    assign sample_count = count_reg;
    assign sample_total = total_reg;

endmodule

FILE: rtl/adctw_ctrl.sv
// Command sequencer: pulse timing, bit shifting and per-tick pin levels.
`include "adc_two_wire_serial_controller_core_macros.svh"

module adctw_ctrl #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic [adctw_pkg::FUNC_W-1:0]      func,
    input  logic [adctw_pkg::DATA_W-1:0]      config_data,
    input  logic                              dout_level,
    input  logic [adctw_pkg::HALF_W-1:0]      half_period,
    input  logic [adctw_pkg::TIMEOUT_W-1:0]   timeout,
    input  logic                              din_invert,
    output adctw_pkg::tick_t                  tick,
    output adctw_pkg::stat_evt_t              evt,
    output logic [adctw_pkg::SAMPLE_W-1:0]    sample,
    output logic [adctw_pkg::DATA_W-1:0]      reg_readback
);
    import adctw_pkg::*;

    localparam logic [PULSE_W-1:0] TRAIL_START = PULSE_W'(SAMPLE_BITS + TRAIL_PULSES);
    localparam logic [PULSE_W-1:0] TRAIL_END   = PULSE_W'(SAMPLE_BITS + EXTRA_LIMIT);
    localparam logic [PULSE_W-1:0] DATA_PULSES = PULSE_W'(SAMPLE_BITS);

    phase_t                  phase_reg, phase_next;
    kind_t                   kind_reg, kind_next;
    logic [PULSE_W-1:0]      pulse_reg, pulse_next;
    logic [TIMER_W-1:0]      timer_reg, timer_next;
    logic [SAMPLE_BITS-1:0]  shift_reg, shift_next;
    logic [DATA_W-1:0]       tx_reg, tx_next;
    logic [SAMPLE_W-1:0]     last_sample_reg, last_sample_next;
    logic [DATA_W-1:0]       readback_reg, readback_next;

    logic [HALF_W-1:0]       h_eff;
    logic [HALF_W:0]         twoh;
    logic [TIMER_W:0]        t1;
    logic [TIMER_W-1:0]      t1w;
    logic                    pulse_wrap;
    logic                    sck_hi;
    logic                    timer_zero;
    logic                    read_finish;
    logic                    reg_finish;
    logic                    wait_timeout;
    logic [TIMER_W-1:0]      adv_timer;
    logic [PULSE_W-1:0]      adv_pulse;
    logic [CMD_W-1:0]        cmd_word;
    logic [PULSE_W-1:0]      cmd_off;
    logic [PULSE_W-1:0]      data_off;
    logic [SUM_W-1:0]        sext;

    assign h_eff        = (half_period == '0) ? HALF_W'(1) : half_period;
    assign twoh         = {h_eff, 1'b0};
    assign t1           = {1'b0, timer_reg} + (TIMER_W+1)'(1);
    assign t1w          = t1[TIMER_W-1:0];
    assign pulse_wrap   = t1 >= (TIMER_W+1)'(twoh);
    assign sck_hi       = timer_reg < TIMER_W'(h_eff);
    assign timer_zero   = timer_reg == '0;
    assign read_finish  = timer_zero && (pulse_reg >= TRAIL_START)
                          && (dout_level || (pulse_reg >= TRAIL_END));
    assign reg_finish   = timer_zero && (pulse_reg >= REG_END);
    assign wait_timeout = t1w >= timeout;
    assign adv_timer    = pulse_wrap ? '0 : t1w;
    assign adv_pulse    = pulse_wrap ? pulse_reg + PULSE_W'(1) : pulse_reg;
    assign cmd_word     = (kind_reg == KIND_WRITE) ? CMD_WR : CMD_RD;
    assign cmd_off      = CMD_LAST - pulse_reg;
    assign data_off     = DATA_LAST - pulse_reg;
    assign sext         = {{(SUM_W-SAMPLE_BITS){shift_reg[SAMPLE_BITS-1]}}, shift_reg};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (func == FUNC_READ && !dout_level)
                    phase_next = PH_READ;
                else if (func == FUNC_WRITE || func == FUNC_REGRD)
                    phase_next = PH_WAIT;
            end
            PH_READ:
            begin
                if (read_finish)
                    phase_next = PH_IDLE;
            end
            PH_WAIT:
            begin
                if (!dout_level)
                    phase_next = PH_REG;
                else if (wait_timeout)
                    phase_next = PH_IDLE;
            end
            PH_REG:
            begin
                if (reg_finish)
                    phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // pin levels and datapath
    always_comb
    begin
        tick             = '0;
        evt              = '0;
        evt.value        = sext;
        kind_next        = kind_reg;
        pulse_next       = pulse_reg;
        timer_next       = timer_reg;
        shift_next       = shift_reg;
        tx_next          = tx_reg;
        last_sample_next = last_sample_reg;
        readback_next    = readback_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (func == FUNC_READ)
                begin
                    if (dout_level)
                    begin
                        tick.done   = 1'b1;
                        tick.status = ST_NOT_READY;
                    end
                    else
                    begin
                        kind_next  = KIND_SAMPLE;
                        pulse_next = '0;
                        timer_next = '0;
                        shift_next = '0;
                    end
                end
                else if (func == FUNC_WRITE || func == FUNC_REGRD)
                begin
                    kind_next  = (func == FUNC_WRITE) ? KIND_WRITE : KIND_READ;
                    pulse_next = '0;
                    timer_next = '0;
                    tx_next    = (func == FUNC_WRITE) ? config_data : '0;
                end
                else if (func == FUNC_CLEAR)
                begin
                    evt.clear = 1'b1;
                    tick.done = 1'b1;
                end
            end
            PH_READ:
            begin
                if (read_finish)
                begin
                    last_sample_next = sext[SAMPLE_W-1:0];
                    evt.add          = 1'b1;
                    tick.done        = 1'b1;
                end
                else
                begin
                    tick.sck = sck_hi;
                    if (pulse_reg < DATA_PULSES && t1 == (TIMER_W+1)'(h_eff))
                        shift_next = {shift_reg[SAMPLE_BITS-2:0], dout_level};
                    timer_next = adv_timer;
                    pulse_next = adv_pulse;
                end
            end
            PH_WAIT:
            begin
                if (!dout_level)
                begin
                    timer_next = '0;
                    pulse_next = '0;
                end
                else
                begin
                    timer_next = t1w;
                    if (wait_timeout)
                    begin
                        tick.done   = 1'b1;
                        tick.status = ST_TIMEOUT;
                    end
                end
            end
            PH_REG:
            begin
                if (reg_finish)
                begin
                    if (kind_reg == KIND_READ)
                        readback_next = tx_reg;
                    tick.done = 1'b1;
                end
                else
                begin
                    tick.sck = sck_hi;
                    if (pulse_reg >= CMD_FIRST && pulse_reg <= CMD_LAST)
                        tick.din = cmd_word[cmd_off[2:0]] ^ din_invert;
                    else if (pulse_reg >= DATA_FIRST && pulse_reg <= DATA_LAST)
                    begin
                        if (kind_reg == KIND_WRITE)
                            tick.din = tx_reg[data_off[2:0]] ^ din_invert;
                        else if (pulse_wrap)
                            tx_next = {tx_reg[DATA_W-2:0], dout_level};
                    end
                    timer_next = adv_timer;
                    pulse_next = adv_pulse;
                end
            end
            default: tick = '0;
        endcase
        tick.busy = phase_next != PH_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            kind_reg        <= KIND_SAMPLE;
            pulse_reg       <= '0;
            timer_reg       <= '0;
            shift_reg       <= '0;
            tx_reg          <= '0;
            last_sample_reg <= '0;
            readback_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            kind_reg        <= kind_next;
            pulse_reg       <= pulse_next;
            timer_reg       <= timer_next;
            shift_reg       <= shift_next;
            tx_reg          <= tx_next;
            last_sample_reg <= last_sample_next;
            readback_reg    <= readback_next;
        end
    end

    assign sample       = last_sample_reg;
    assign reg_readback = readback_reg;

    `ADCTW_ASSERT(a_done_ends_cmd, step && tick.done, !tick.busy)
    `ADCTW_ASSERT(a_status_only_on_done, step && tick.status != ST_OK, tick.done)
    `ADCTW_ASSERT(a_reg_pulse_bound, phase_reg == PH_REG, pulse_reg <= REG_END)
    `ADCTW_ASSERT_NEXT(a_stats_only_in_read, step && evt.add, phase_reg == PH_IDLE)

endmodule

FILE: rtl/adc_two_wire_serial_controller_core.sv
// Top level of the two-wire converter link controller: handshakes, config and result registers.
//
//  channel | direction | handshake           | words
//  in      | into core | in_valid / in_stall  | func, config_data, dout_level
//  out     | from core | out_valid / out_stall| pin levels, status, sample, stats
//  cfg     | into core | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One tick word is taken every cycle unless a stalled result holds the flow; its result is registered.
// Path: input register, one pass of sequencer logic, result register.
// Reset returns to idle with registers at 50, 50000000 and 1; no clearing pass.
// A stalled result holds the next word in the input register; further input stalls.
// Config is always ready and applies from the next tick.
module adc_two_wire_serial_controller_core #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [adctw_pkg::FUNC_W-1:0]        func,
    input  logic [adctw_pkg::DATA_W-1:0]        config_data,
    input  logic                                dout_level,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                sck_level,
    output logic                                din_level,
    output logic                                busy_res,
    output logic                                done_res,
    output logic [adctw_pkg::STATUS_W-1:0]      status,
    output logic signed [adctw_pkg::SAMPLE_W-1:0] sample,
    output logic [adctw_pkg::DATA_W-1:0]        reg_readback,
    output logic signed [adctw_pkg::SUM_W-1:0]  sample_sum,
    output logic [adctw_pkg::COUNT_W-1:0]       sample_count,
    output logic [adctw_pkg::COUNT_W-1:0]       sample_total,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [adctw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [adctw_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import adctw_pkg::*;

    logic                  in_valid_reg;
    logic [FUNC_W-1:0]     func_reg;
    logic [DATA_W-1:0]     data_reg;
    logic                  dout_reg;
    logic                  out_valid_reg;
    tick_t                 tick_reg;
    tick_t                 tick_next;
    stat_evt_t             evt;
    logic                  step;
    logic                  in_take;
    logic [HALF_W-1:0]     half_reg;
    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic                  invert_reg;
    logic [SAMPLE_W-1:0]   sample_raw;
    logic [SUM_W-1:0]      sum_raw;

    assign step      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !step;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= HALF_RESET;
            timeout_reg <= TIMEOUT_RESET;
            invert_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HALF:    half_reg    <= cfg_data[HALF_W-1:0];
                CFG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                CFG_INVERT:  invert_reg  <= cfg_data[0];
                default:     half_reg    <= half_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;
            if (step)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= func;
            data_reg <= config_data;
            dout_reg <= dout_level;
        end
        if (step)
            tick_reg <= tick_next;
    end

    adctw_ctrl #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .func         (func_reg),
        .config_data  (data_reg),
        .dout_level   (dout_reg),
        .half_period  (half_reg),
        .timeout      (timeout_reg),
        .din_invert   (invert_reg),
        .tick         (tick_next),
        .evt          (evt),
        .sample       (sample_raw),
        .reg_readback (reg_readback)
    );

    adctw_stats u_stats (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .evt          (evt),
        .sample_sum   (sum_raw),
        .sample_count (sample_count),
        .sample_total (sample_total)
    );

    assign out_valid  = out_valid_reg;
    assign sck_level  = tick_reg.sck;
    assign din_level  = tick_reg.din;
    assign busy_res   = tick_reg.busy;
    assign done_res   = tick_reg.done;
    assign status     = tick_reg.status;
    assign sample     = $signed(sample_raw);
    assign sample_sum = $signed(sum_raw);

endmodule

FILE: test/tb_top.sv
// Testbench for the two-wire converter link controller: tick predictor, scoreboard, random ticks.
`timescale 1ns / 100ps

module tb_top;
    import adctw_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 240;
    localparam int N_DIRECTED     = 18;

    // func codes the block ignores
    localparam logic [FUNC_W-1:0] FUNC_RSV5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RSV6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSV7 = 3'd7;

    typedef struct packed {
        logic                sck;
        logic                din;
        logic                busy;
        logic                done;
        logic [STATUS_W-1:0] status;
        logic [SAMPLE_W-1:0] sample;
        logic [DATA_W-1:0]   readback;
        logic [SUM_W-1:0]    sum;
        logic [COUNT_W-1:0]  count;
        logic [COUNT_W-1:0]  total;
    } link_result_t;

    class adc_link_scoreboard;
        logic [HALF_W-1:0]    half = HALF_RESET;
        logic [TIMEOUT_W-1:0] tout = TIMEOUT_RESET;
        logic                 inv  = 1'b1;
        phase_t               ph   = PH_IDLE;
        kind_t                kind = KIND_SAMPLE;
        logic [PULSE_W-1:0]   pulse = '0;
        logic [TIMER_W-1:0]   timer = '0;
        logic [SAMPLE_W-1:0]  shift_word = '0;
        logic [DATA_W-1:0]    tx = '0;
        logic [SAMPLE_W-1:0]  last_sample = '0;
        logic [DATA_W-1:0]    last_rb = '0;
        logic [SUM_W-1:0]     sum = '0;
        logic [COUNT_W-1:0]   count = '0;
        logic [COUNT_W-1:0]   total = '0;
        link_result_t         pending_q[$];
        int ticks, results, errors;
        int n_samples, n_regs, n_timeouts, n_notready, n_clears;

        function int pending();
            return pending_q.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_HALF:    half = val[HALF_W-1:0];
                CFG_TIMEOUT: tout = val;
                CFG_INVERT:  inv  = val[0];
                default: ;
            endcase
        endfunction

        function void advance(longint unsigned twoh);
            longint unsigned t64;
            timer = timer + 1'b1;
            t64 = timer;
            if (t64 >= twoh)
            begin
                timer = '0;
                pulse = pulse + 1'b1;
            end
        endfunction

        function void note_tick(logic [FUNC_W-1:0] fn, logic [DATA_W-1:0] cd, logic dl);
            link_result_t     r;
            longint unsigned  h;
            longint unsigned  twoh;
            longint unsigned  t64;
            logic [CMD_W-1:0] cmd;
            logic [SUM_W-1:0] ext;
            r = '0;
            h = (half == 0) ? 1 : half;
            twoh = 2 * h;
            t64 = timer;
            ticks++;
            case (ph)
                PH_IDLE:
                begin
                    if (fn == FUNC_READ)
                    begin
                        if (dl)
                        begin
                            r.done = 1'b1;
                            r.status = ST_NOT_READY;
                            n_notready++;
                        end
                        else
                        begin
                            ph = PH_READ;
                            kind = KIND_SAMPLE;
                            pulse = '0;
                            timer = '0;
                            shift_word = '0;
                        end
                    end
                    else if (fn == FUNC_WRITE || fn == FUNC_REGRD)
                    begin
                        ph = PH_WAIT;
                        kind = (fn == FUNC_WRITE) ? KIND_WRITE : KIND_READ;
                        timer = '0;
                        pulse = '0;
                        tx = (fn == FUNC_WRITE) ? cd : '0;
                    end
                    else if (fn == FUNC_CLEAR)
                    begin
                        sum = '0;
                        count = '0;
                        r.done = 1'b1;
                        n_clears++;
                    end
                end
                PH_READ:
                begin
                    if (timer == 0 && pulse >= SAMPLE_W + TRAIL_PULSES &&
                        (dl || pulse >= SAMPLE_W + EXTRA_LIMIT))
                    begin
                        ext = {{(SUM_W-SAMPLE_W){shift_word[SAMPLE_W-1]}}, shift_word};
                        last_sample = shift_word;
                        sum = sum + ext;
                        count = count + 1'b1;
                        total = total + 1'b1;
                        r.done = 1'b1;
                        ph = PH_IDLE;
                        n_samples++;
                    end
                    else
                    begin
                        r.sck = (t64 < h);
                        if (pulse < SAMPLE_W && t64 + 1 == h)
                            shift_word = {shift_word[SAMPLE_W-2:0], dl};
                        advance(twoh);
                    end
                end
                PH_WAIT:
                begin
                    if (!dl)
                    begin
                        ph = PH_REG;
                        timer = '0;
                        pulse = '0;
                    end
                    else
                    begin
                        timer = timer + 1'b1;
                        if (timer >= tout)
                        begin
                            r.done = 1'b1;
                            r.status = ST_TIMEOUT;
                            ph = PH_IDLE;
                            n_timeouts++;
                        end
                    end
                end
                PH_REG:
                begin
                    if (timer == 0 && pulse >= REG_END)
                    begin
                        if (kind == KIND_READ)
                            last_rb = tx;
                        r.done = 1'b1;
                        ph = PH_IDLE;
                        n_regs++;
                    end
                    else
                    begin
                        r.sck = (t64 < h);
                        cmd = (kind == KIND_WRITE) ? CMD_WR : CMD_RD;
                        if (pulse >= CMD_FIRST && pulse <= CMD_LAST)
                            r.din = cmd[CMD_LAST - pulse] ^ inv;
                        else if (pulse >= DATA_FIRST && pulse <= DATA_LAST)
                        begin
                            if (kind == KIND_WRITE)
                                r.din = tx[DATA_LAST - pulse] ^ inv;
                            else if (t64 + 1 >= twoh)
                                tx = {tx[DATA_W-2:0], dl};
                        end
                        advance(twoh);
                    end
                end
                default: ph = PH_IDLE;
            endcase
            r.busy = (ph != PH_IDLE);
            r.sample = last_sample;
            r.readback = last_rb;
            r.sum = sum;
            r.count = count;
            r.total = total;
            pending_q.push_back(r);
        endfunction

        function void check_field(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a)
            begin
                errors++;
                if (errors <= 10)
                    $display("word %0d, %s: expected %0h, got %0h", results, name, e, a);
            end
        endfunction

        function void check_result(link_result_t act);
            link_result_t want;
            results++;
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("word %0d arrived with nothing pending", results);
                return;
            end
            want = pending_q.pop_front();
            check_field("sck_level", want.sck, act.sck);
            check_field("din_level", want.din, act.din);
            check_field("busy_res", want.busy, act.busy);
            check_field("done_res", want.done, act.done);
            check_field("status", want.status, act.status);
            check_field("sample", want.sample, act.sample);
            check_field("reg_readback", want.readback, act.readback);
            check_field("sample_sum", want.sum, act.sum);
            check_field("sample_count", want.count, act.count);
            check_field("sample_total", want.total, act.total);
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [FUNC_W-1:0]           func;
    logic [DATA_W-1:0]           config_data;
    logic                        dout_level;
    logic                        out_valid;
    logic                        out_stall;
    logic                        sck_level;
    logic                        din_level;
    logic                        busy_res;
    logic                        done_res;
    logic [STATUS_W-1:0]         status;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [DATA_W-1:0]           reg_readback;
    logic signed [SUM_W-1:0]     sample_sum;
    logic [COUNT_W-1:0]          sample_count;
    logic [COUNT_W-1:0]          sample_total;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    adc_link_scoreboard sb;
    int                 idle_pct = 0;
    bit                 calm = 0;
    bit                 held = 0;
    int                 stuck = 0;
    logic [SAMPLE_W-1:0] plan_word;
    logic [DATA_W-1:0]   plan_byte;
    int                  plan_end;
    int                  plan_wait;

    localparam logic [11:0] DIRECTED [N_DIRECTED] = '{
        {FUNC_TICK,  8'h00, 1'b0},
        {FUNC_RSV7,  8'hFF, 1'b1},
        {FUNC_RSV5,  8'hAA, 1'b0},
        {FUNC_RSV6,  8'h55, 1'b1},
        {FUNC_READ,  8'h00, 1'b1},
        {FUNC_CLEAR, 8'hFF, 1'b0},
        {FUNC_WRITE, 8'hFF, 1'b1},
        {FUNC_TICK,  8'h00, 1'b1},
        {FUNC_TICK,  8'h00, 1'b1},
        {FUNC_REGRD, 8'h00, 1'b0},
        {FUNC_READ,  8'h00, 1'b1},
        {FUNC_CLEAR, 8'h00, 1'b1},
        {FUNC_WRITE, 8'hA5, 1'b0},
        {FUNC_TICK,  8'h00, 1'b0},
        {FUNC_REGRD, 8'hFF, 1'b1},
        {FUNC_READ,  8'h00, 1'b0},
        {FUNC_CLEAR, 8'h00, 1'b1},
        {FUNC_TICK,  8'h00, 1'b0}
    };

    adc_two_wire_serial_controller_core DUT (.*);

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({sck_level, din_level, busy_res, done_res, status, sample,
                             reg_readback, sample_sum, sample_count, sample_total});
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                stuck = 0;
            else
            begin
                stuck++;
                if (stuck >= WATCHDOG_LIMIT)
                begin
                    $display("no word moved for %0d cycles", stuck);
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

    // result side: random stall bursts plus one long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && sb.ticks >= 80)
            begin
                held = 1;
                out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < idle_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_tick(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] cd,
                             input logic dl);
        bit took;
        in_valid <= 1'b1;
        func <= fn;
        config_data <= cd;
        dout_level <= dl;
        took = 0;
        while (!took)
        begin
            @(negedge clk);
            took = !in_stall;
            if (took)
                sb.note_tick(fn, cd, dl);
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        took = 0;
        while (!took)
        begin
            @(negedge clk);
            took = cfg_ready;
            if (took)
                sb.set_reg(idx, val);
            @(posedge clk);
        end
    endtask

    task automatic set_regs(input logic [HALF_W-1:0] h, input logic [TIMEOUT_W-1:0] t,
                            input logic inv);
        write_reg(CFG_HALF, CFG_DATA_W'(h));
        write_reg(CFG_TIMEOUT, t);
        write_reg(CFG_INVERT, CFG_DATA_W'(inv));
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // shape the next tick from the predicted controller state
    function automatic void pick_tick(output logic [FUNC_W-1:0] fn,
                                      output logic [DATA_W-1:0] cd, output logic dl);
        int r;
        int mode;
        cd = DATA_W'($urandom);
        fn = FUNC_W'($urandom_range(FUNC_TICK, FUNC_RSV7));
        dl = 1'($urandom_range(0, 1));
        case (sb.ph)
            PH_IDLE:
            begin
                mode = $urandom_range(0, 9);
                case (mode)
                    0: plan_word = 24'h800000;
                    1: plan_word = 24'h7FFFFF;
                    2: plan_word = 24'hFFFFFF;
                    3: plan_word = 24'h000000;
                    default: plan_word = SAMPLE_W'($urandom);
                endcase
                plan_byte = DATA_W'($urandom);
                plan_end = $urandom_range(0, 6);
                plan_wait = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12)
                                                         : $urandom_range(0, 3);
                r = $urandom_range(0, 99);
                if (r < 40)
                begin
                    fn = FUNC_READ;
                    dl = (r < 4);
                end
                else if (r < 55)
                    fn = FUNC_WRITE;
                else if (r < 70)
                    fn = FUNC_REGRD;
                else if (r < 76)
                    fn = FUNC_CLEAR;
                else if (r < 88)
                    fn = FUNC_TICK;
                else
                    fn = FUNC_W'($urandom_range(FUNC_RSV5, FUNC_RSV7));
            end
            PH_READ:
            begin
                if (sb.pulse < SAMPLE_W)
                    dl = plan_word[SAMPLE_W - 1 - sb.pulse];
                else if (sb.pulse >= SAMPLE_W + TRAIL_PULSES)
                    dl = (sb.pulse >= SAMPLE_W + TRAIL_PULSES + plan_end);
            end
            PH_WAIT: dl = (sb.timer < plan_wait);
            PH_REG:
            begin
                if (sb.pulse >= DATA_FIRST && sb.pulse <= DATA_LAST)
                    dl = plan_byte[DATA_LAST - sb.pulse];
            end
            default: ;
        endcase
    endfunction

    task automatic run_phase(input logic [HALF_W-1:0] h, input logic [TIMEOUT_W-1:0] t,
                             input logic inv, input int pct, input int budget,
                             input int calm_tail);
        logic [FUNC_W-1:0] fn;
        logic [DATA_W-1:0] cd;
        logic              dl;
        settle();
        set_regs(h, t, inv);
        idle_pct = pct;
        for (int n = 0; n < budget; n++)
        begin
            if (n >= budget - calm_tail)
                calm = 1;
            if (!calm && $urandom_range(0, 99) < idle_pct)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            pick_tick(fn, cd, dl);
            send_tick(fn, cd, dl);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_TICK;
        config_data = '0;
        dout_level = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_HALF;
        cfg_data = '0;
        sb = new;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_regs(16'd1, 32'd2, 1'b1);
        for (int i = 0; i < N_DIRECTED; i++)
            send_tick(DIRECTED[i][11:9], DIRECTED[i][8:1], DIRECTED[i][0]);

        run_phase(16'd1, 32'd3, 1'b1, 15, 130, 0);
        run_phase(16'd0, 32'd1, 1'b0, 0, 100, 0);
        run_phase(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 10, 30, 0);
        run_phase(16'd2, 32'd0, 1'b0, 20, 130, 0);
        run_phase(16'd1, 32'd8, 1'b1, 15, 160, 100);
        settle();

        $display("Ran %0d ticks: %0d samples, %0d register accesses, %0d timeouts,",
                 sb.ticks, sb.n_samples, sb.n_regs, sb.n_timeouts);
        $display("%0d not-ready reads, %0d clears; %0d words checked, %0d field mismatches.",
                 sb.n_notready, sb.n_clears, sb.results, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: adc_two_wire_serial_controller_core.f
+incdir+rtl
rtl/adctw_pkg.sv
rtl/adctw_stats.sv
rtl/adctw_ctrl.sv
rtl/adc_two_wire_serial_controller_core.sv
test/tb_top.sv
